### rtl/core/can_btc_pkg.sv
// ----------------------------------------------------------------------------
// CAN bit timing calculator package
// Widths, constants, divider status and timing byte encoding.
// ----------------------------------------------------------------------------
package can_btc_pkg;

  localparam int OSC_W = 26;
  localparam int RATE_W = 20;
  localparam int QUO_W = 5;
  localparam int BYTE_W = 8;

  localparam logic [OSC_W-1:0] OSC_RESET = 26'd16000000;
  localparam logic [QUO_W-1:0] QUANTA_MIN = 5'd5;
  localparam logic [QUO_W-1:0] QUANTA_MAX = 5'd25;
  localparam logic [BYTE_W-1:0] CNF2_FIXED = 8'h80;
  localparam logic [BYTE_W-1:0] PROP_FIELD = 8'h01;
  localparam logic [BYTE_W-1:0] PS2_MIN = 8'd2;
  localparam logic [BYTE_W-1:0] SEG_FIXED = 8'd3;

  typedef struct packed {
    logic             done;
    logic             over;
    logic [QUO_W-1:0] quo;
  } div_status_t;

  // phase1 = q/2, prop = 2
  function automatic logic [BYTE_W-1:0] enc_byte_two(input logic [QUO_W-1:0] q);
    logic [BYTE_W-1:0] ps1;
    ps1 = BYTE_W'(q >> 1);
    return CNF2_FIXED | BYTE_W'((ps1 - 8'd1) << 3) | PROP_FIELD;
  endfunction

  // phase2 = q - 3 - phase1, floor 2; q is at least 5 here
  function automatic logic [BYTE_W-1:0] enc_byte_three(input logic [QUO_W-1:0] q);
    logic [BYTE_W-1:0] ps1;
    logic [BYTE_W-1:0] ps2;
    ps1 = BYTE_W'(q >> 1);
    ps2 = BYTE_W'(q) - SEG_FIXED - ps1;
    if (ps2 < PS2_MIN) begin
      ps2 = PS2_MIN;
    end
    return ps2 - 8'd1;
  endfunction

endpackage

### rtl/core/can_btc_div.sv
// ----------------------------------------------------------------------------
// CAN bit timing quotient unit
// Restoring divider, one quotient bit per cycle; flags quotients above 31.
// ----------------------------------------------------------------------------
module can_btc_div import can_btc_pkg::*; #(
  parameter int DW = 27
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [OSC_W-1:0]  dividend,
  input  logic [DW-1:0]     divisor,
  output div_status_t       status
);

  localparam int SW = DW + QUO_W;

  logic             busy;
  logic [2:0]       cnt;
  logic [OSC_W-1:0] rem;
  logic [SW-1:0]    dsr;
  logic [QUO_W-1:0] quo;
  logic [SW-1:0]    rem_ext;
  logic [SW-1:0]    diff;
  logic             ge;
  logic             over_now;

  assign rem_ext = {{(SW-OSC_W){1'b0}}, rem};
  assign ge = rem_ext >= dsr;
  assign diff = rem_ext - dsr;
  assign over_now = (cnt == 3'(QUO_W)) && ge;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      status <= '0;
    end else begin
      status.done <= busy && !start && (over_now || cnt == 3'd0);
      if (start) begin
        busy <= 1'b1;
        cnt <= 3'(QUO_W);
        rem <= dividend;
        dsr <= {divisor, {QUO_W{1'b0}}};
        quo <= '0;
      end else if (busy) begin
        if (over_now) begin
          busy <= 1'b0;
          status.over <= 1'b1;
        end else begin
          if (ge) begin
            rem <= diff[OSC_W-1:0];
          end
          quo <= {quo[QUO_W-2:0], ge};
          dsr <= dsr >> 1;
          cnt <= cnt - 3'd1;
          if (cnt == 3'd0) begin
            busy <= 1'b0;
            status.over <= 1'b0;
            status.quo <= {quo[QUO_W-2:0], ge};
          end
        end
      end
    end
  end

endmodule

### rtl/core/can_bit_timing_calculator.sv
// ----------------------------------------------------------------------------
// CAN bit timing calculator
// Searches prescalers for 5..25 quanta per bit and encodes three timing bytes.
// ----------------------------------------------------------------------------
// channel  | handshake              | payload
// ---------+------------------------+-----------------------------------------
// input    | in_valid / in_ready    | bit_rate_hz
// output   | out_valid / out_ready  | found, timing_byte_one/two/three
// config   | cfg_wr_en              | cfg_wr_data (oscillator frequency)
//
// Each prescaler trial steps through start, 6 divider bits and the check,
// and ends early when the quotient exceeds 31.
// The search stops early once the quanta count drops below 5.
// A zero rate skips the search. Synchronous reset sets the oscillator
// frequency to 16000000. in_ready is high only between words; a finished
// result waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module can_bit_timing_calculator import can_btc_pkg::*; #(
  parameter int PRESCALER_STEPS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [OSC_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [RATE_W-1:0] bit_rate_hz,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              found,
  output logic [BYTE_W-1:0] timing_byte_one,
  output logic [BYTE_W-1:0] timing_byte_two,
  output logic [BYTE_W-1:0] timing_byte_three
);

  localparam int PW = (PRESCALER_STEPS > 1) ? $clog2(PRESCALER_STEPS) : 1;
  localparam int DW = RATE_W + 1 + PW;
  localparam logic [PW-1:0] LAST = PW'(PRESCALER_STEPS - 1);

  typedef enum logic [1:0] {S_IDLE, S_START, S_DIV, S_DONE} state_t;

  state_t           state;
  logic [OSC_W-1:0] osc;
  logic [DW-1:0]    step;
  logic [DW-1:0]    dvs;
  logic [PW-1:0]    presc;
  logic             hit;
  logic [QUO_W-1:0] quanta;
  div_status_t      div_st;
  logic             out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  can_btc_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_START),
    .dividend (osc),
    .divisor  (dvs),
    .status   (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      osc <= OSC_RESET;
    end else if (cfg_wr_en) begin
      osc <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      hit <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            step <= DW'({bit_rate_hz, 1'b0});
            dvs <= DW'({bit_rate_hz, 1'b0});
            presc <= '0;
            hit <= 1'b0;
            state <= (bit_rate_hz == '0) ? S_DONE : S_START;
          end
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_st.done) begin
            if (!div_st.over && div_st.quo < QUANTA_MIN) begin
              state <= S_DONE;
            end else if (!div_st.over && div_st.quo <= QUANTA_MAX) begin
              hit <= 1'b1;
              quanta <= div_st.quo;
              state <= S_DONE;
            end else if (presc == LAST) begin
              state <= S_DONE;
            end else begin
              presc <= presc + 1'b1;
              dvs <= dvs + step;
              state <= S_START;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            found <= hit;
            timing_byte_one <= hit ? BYTE_W'(presc) : '0;
            timing_byte_two <= hit ? enc_byte_two(quanta) : '0;
            timing_byte_three <= hit ? enc_byte_three(quanta) : '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == S_DIV)
    else $error("divider finished outside a trial");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> timing_byte_one == '0 && timing_byte_two == '0
      && timing_byte_three == '0)
    else $error("failed word carries nonzero timing bytes");

  a_byte_two_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> timing_byte_two[7] && timing_byte_two[2:0] == 3'd1)
    else $error("timing byte two fixed bits wrong");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accepting a word");

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CAN bit timing calculator testbench
// Sends bit rates under several oscillator settings and checks the timing
// bytes against a prescaler search kept in the bench. The sender works in
// bursts with random gaps. The receiver stalls on changing patterns, and one
// long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module tb;
  import can_btc_pkg::*;

  localparam int STEPS = 64;
  localparam int PROP_TQ = 2;
  localparam logic [BYTE_W-1:0] PRESC_MASK = 8'h3F;
  localparam logic [RATE_W-1:0] RATE_MAX = 20'hFFFFF;
  localparam logic [OSC_W-1:0] OSC_MAX = 26'h3FFFFFF;
  localparam int HOLD_CYCLES = 3000;
  localparam int TAIL_CYCLES = 600;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int MAX_PRINTS = 40;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              found;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
  } timing_t;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [OSC_W-1:0]  cfg_wr_data;
  logic              in_valid;
  logic              in_ready;
  logic [RATE_W-1:0] bit_rate_hz;
  logic              out_valid;
  logic              out_ready;
  logic              found;
  logic [BYTE_W-1:0] timing_byte_one;
  logic [BYTE_W-1:0] timing_byte_two;
  logic [BYTE_W-1:0] timing_byte_three;

  logic [OSC_W-1:0]  osc_hz;
  timing_t           timing_q[$];
  logic [RATE_W-1:0] rate_q[$];
  timing_t           want;
  int                err_count;
  int                idle_cycles;
  logic              hold_req;
  int                hold_left;
  int                pattern_left;
  rx_mode_t          rx_mode;

  can_bit_timing_calculator #(
    .PRESCALER_STEPS(STEPS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .bit_rate_hz(bit_rate_hz),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .found(found),
    .timing_byte_one(timing_byte_one),
    .timing_byte_two(timing_byte_two),
    .timing_byte_three(timing_byte_three)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // first prescaler giving 5..25 quanta, then segment encoding
  function automatic timing_t calc_timing(input logic [RATE_W-1:0] rate,
                                          input logic [OSC_W-1:0] osc);
    timing_t t;
    longint unsigned q;
    longint unsigned divisor;
    longint unsigned ps1;
    longint unsigned ps2;
    int p;
    t = '0;
    t.rate = rate;
    q = 0;
    if (rate != 0) begin
      for (p = 0; p < STEPS && !t.found; p++) begin
        divisor = longint'(rate) * longint'(2 * (p + 1));
        q = longint'(osc) / divisor;
        if (q >= QUANTA_MIN && q <= QUANTA_MAX) begin
          t.found = 1'b1;
          t.b1 = BYTE_W'(p) & PRESC_MASK;
        end
      end
    end
    if (t.found) begin
      ps1 = q / 2;
      if (ps1 < 1) begin
        ps1 = 1;
      end
      ps2 = (q >= 1 + PROP_TQ + ps1) ? q - (1 + PROP_TQ + ps1) : 0;
      ps2 = ps2 & 64'hFF;
      if (ps2 < 2) begin
        ps2 = 2;
      end
      t.b2 = BYTE_W'(CNF2_FIXED | ((ps1 - 1) << 3) | (PROP_TQ - 1));
      t.b3 = BYTE_W'(ps2 - 1);
    end
    return t;
  endfunction

  // mostly rates aimed at a random prescaler and quanta count
  function automatic logic [RATE_W-1:0] pick_rate();
    longint unsigned base;
    longint unsigned r;
    int sel;
    int p;
    int q;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      p = $urandom_range(0, STEPS - 1);
      q = $urandom_range(5, 25);
      base = longint'(osc_hz) / longint'(2 * (p + 1) * q);
      r = base - base / 16 + $urandom_range(0, int'(base / 8));
      if (r > RATE_MAX) begin
        r = RATE_MAX;
      end
      return RATE_W'(r);
    end else if (sel < 80) begin
      case ($urandom_range(0, 5))
        0: return 20'd10000;
        1: return 20'd50000;
        2: return 20'd125000;
        3: return 20'd250000;
        4: return 20'd500000;
        default: return 20'd1000000;
      endcase
    end else if (sel < 92) begin
      return RATE_W'($urandom_range(0, RATE_MAX));
    end
    return RATE_W'($urandom_range(0, 40));
  endfunction

  task automatic note_mismatch(input string msg);
    if (err_count < MAX_PRINTS) begin
      $display("tb: mismatch: %s", msg);
    end
    err_count++;
  endtask

  task automatic send_word(input logic [RATE_W-1:0] rate, input logic last);
    @(negedge clk);
    in_valid <= 1'b1;
    bit_rate_hz <= rate;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    timing_q.push_back(calc_timing(rate, osc_hz));
    if (last) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // sends everything in rate_q, in bursts with random gaps
  task automatic send_queued();
    int burst;
    int gap;
    int sel;
    logic last;
    burst = 0;
    while (rate_q.size() != 0) begin
      if (burst == 0) begin
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      end
      burst--;
      last = (burst == 0) || (rate_q.size() == 1);
      send_word(rate_q.pop_front(), last);
      if (last && rate_q.size() != 0) begin
        sel = $urandom_range(0, 99);
        if (sel < 75) begin
          gap = $urandom_range(0, 6);
        end else if (sel < 95) begin
          gap = $urandom_range(10, 60);
        end else begin
          gap = $urandom_range(200, 700);
        end
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    while (timing_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_oscillator(input logic [OSC_W-1:0] value);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    osc_hz = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_reset_setting();
    rate_q = '{20'd0, RATE_MAX, 20'd1, 20'd1000000, 20'd800000, 20'd500000,
               20'd320000, 20'd307692, 20'd250000, 20'd125000, 20'd100000,
               20'd50000, 20'd10000, 20'd5100, 20'd5000, 20'd4900,
               20'h55555, 20'hAAAAA};
    send_queued();
  endtask

  task automatic test_oscillator_extremes();
    logic [OSC_W-1:0] osc_list[6];
    int i;
    int k;
    osc_list = '{26'd1000000, 26'd40000000, 26'd0, OSC_MAX, 26'd8000000,
                 26'd20000000};
    for (i = 0; i < 6; i++) begin
      set_oscillator(osc_list[i]);
      rate_q = '{20'd0, RATE_MAX, 20'd100000, 20'd100001};
      for (k = 0; k < 5; k++) begin
        rate_q.push_back(pick_rate());
      end
      send_queued();
    end
  endtask

  task automatic test_random_sweep();
    int ph;
    int k;
    for (ph = 0; ph < 5; ph++) begin
      set_oscillator(OSC_W'($urandom_range(1000000, 40000000)));
      for (k = 0; k < 36; k++) begin
        rate_q.push_back(pick_rate());
      end
      send_queued();
    end
  endtask

  // receiver holds off while words keep coming, so the input stalls
  task automatic test_output_hold_off();
    int k;
    wait_drained();
    hold_req = 1'b1;
    for (k = 0; k < 10; k++) begin
      rate_q.push_back(pick_rate());
    end
    send_queued();
  endtask

  task automatic test_drain_pause();
    int rep;
    int k;
    for (rep = 0; rep < 2; rep++) begin
      for (k = 0; k < 10; k++) begin
        rate_q.push_back(pick_rate());
      end
      send_queued();
      wait_drained();
    end
  endtask

  // receiver: changing stall patterns plus the one long hold-off
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(20, 300);
        rx_mode = rx_mode_t'($urandom_range(0, 3));
      end
      pattern_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN: out_ready <= 1'b1;
          RX_COIN: out_ready <= ($urandom_range(0, 1) == 0);
          RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= (pattern_left % 16) < 10;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (timing_q.size() == 0) begin
        note_mismatch("result word with nothing pending");
      end else begin
        want = timing_q.pop_front();
        if (found !== want.found) begin
          note_mismatch($sformatf("rate %0d osc %0d found %0b want %0b",
                                  want.rate, osc_hz, found, want.found));
        end
        if (timing_byte_one !== want.b1) begin
          note_mismatch($sformatf("rate %0d osc %0d byte one %h want %h",
                                  want.rate, osc_hz, timing_byte_one, want.b1));
        end
        if (timing_byte_two !== want.b2) begin
          note_mismatch($sformatf("rate %0d osc %0d byte two %h want %h",
                                  want.rate, osc_hz, timing_byte_two, want.b2));
        end
        if (timing_byte_three !== want.b3) begin
          note_mismatch($sformatf("rate %0d osc %0d byte three %h want %h",
                                  want.rate, osc_hz, timing_byte_three, want.b3));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    bit_rate_hz = '0;
    out_ready = 1'b0;
    osc_hz = OSC_RESET;
    err_count = 0;
    idle_cycles = 0;
    hold_req = 1'b0;
    hold_left = 0;
    pattern_left = 0;
    rx_mode = RX_OPEN;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_setting();
    test_oscillator_extremes();
    test_random_sweep();
    test_output_hold_off();
    test_drain_pause();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/can_btc_pkg.sv
rtl/core/can_btc_div.sv
rtl/core/can_bit_timing_calculator.sv
test/tb.sv
